// ----- hdl/csq_pkg.sv -----
// Shared types for the complex square root core.
// No dependencies.
package csq_pkg;

  // Sign flags of one item, carried from the front end to the back end.
  typedef struct packed {
    logic re_neg;
    logic im_neg;
  } csq_sign_t;

endpackage

// ----- hdl/csq_front.sv -----
// Front end: unpacks an input item into magnitudes and sign flags.
// Depends on csq_pkg.
module csq_front #(
  parameter int DATA_WIDTH = 32,
  parameter int TDATA_W    = 64
) (
  input  logic [TDATA_W-1:0]    tdata_i,
  output logic [DATA_WIDTH-1:0] re_mag_o,
  output logic [DATA_WIDTH-1:0] im_mag_o,
  output csq_pkg::csq_sign_t    sign_o
);
  import csq_pkg::*;

  logic [DATA_WIDTH-1:0] re_raw;
  logic [DATA_WIDTH-1:0] im_raw;

  assign re_raw = tdata_i[DATA_WIDTH-1:0];
  assign im_raw = tdata_i[2*DATA_WIDTH-1:DATA_WIDTH];

  assign sign_o.re_neg = re_raw[DATA_WIDTH-1];
  assign sign_o.im_neg = im_raw[DATA_WIDTH-1];

  // Most negative code maps to 2^(W-1), which still fits unsigned.
  assign re_mag_o = re_raw[DATA_WIDTH-1] ? (~re_raw + 1'b1) : re_raw;
  assign im_mag_o = im_raw[DATA_WIDTH-1] ? (~im_raw + 1'b1) : im_raw;

endmodule

// ----- hdl/csq_fifo.sv -----
// Small register queue between front end and back end.
// No dependencies.
module csq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/csq_back.sv -----
// Back end: sequencer over one shift-add squarer, one digit-serial root
// unit and one restoring divider, with a registered result. Depends on csq_pkg.
module csq_back #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_pop_o,
  input  logic [DATA_WIDTH-1:0]   re_mag_i,
  input  logic [DATA_WIDTH-1:0]   im_mag_i,
  input  csq_pkg::csq_sign_t      sign_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DATA_WIDTH-2:0]   re_out_o,
  output logic [DATA_WIDTH-1:0]   im_out_o
);
  import csq_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int SW  = W + 1 + F;
  localparam int RW0 = (2 * W > SW) ? 2 * W : SW;
  localparam int RW  = RW0 + (RW0 % 2);
  localparam int RB  = RW / 2;
  localparam int MW  = RB + 3;
  localparam int NW  = W + F;
  localparam int CW  = $clog2(NW + 1);
  localparam int XW  = NW + RB;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQR  = 3'd1;
  localparam logic [2:0] ST_RT1  = 3'd2;
  localparam logic [2:0] ST_RT2  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  a_q, a_d, b_q, b_d, sa_q, sa_d, sb_q, sb_d;
  csq_sign_t     sg_q, sg_d;
  logic [RW-1:0] rad_q, rad_d;
  logic [MW-1:0] rem_q, rem_d;
  logic [RB-1:0] root_q, root_d;
  logic [NW-1:0] num_q, num_d, quo_q, quo_d;
  logic          zero_q, zero_d;

  // Root step
  logic [MW-1:0] rt_rem, rt_trial;
  logic          rt_ge;
  logic [RB-1:0] rt_root;
  // Divide step
  logic [MW-1:0] dv_rem, dv_div;
  // Square step
  logic [RW-1:0] sq_sum;
  // Half of (magnitude + |re|) scaled
  logic [W:0]    hsum;
  logic [SW-1:0] n2;
  // Result saturation
  logic [XW-1:0] r_ext, q_ext, pos_ext;
  logic [W-2:0]  r_sat, q_sat, mag_out, sgn_out;
  // Result register
  logic          load;
  logic          out_v_q, out_v_d;
  logic [W-2:0]  re_cmb, re_q, re_d;
  logic [W-1:0]  im_cmb, im_q, im_d;

  assign sq_sum = (rad_q << 1) + (sa_q[W-1] ? RW'(a_q) : '0)
                               + (sb_q[W-1] ? RW'(b_q) : '0);
  assign rt_rem   = (rem_q << 2) | MW'(rad_q[RW-1:RW-2]);
  assign rt_trial = (MW'(root_q) << 2) | MW'(1);
  assign rt_ge    = (rt_rem >= rt_trial);
  assign rt_root  = {root_q[RB-2:0], rt_ge};
  assign dv_rem   = (rem_q << 1) | MW'(num_q[NW-1]);
  assign dv_div   = MW'(root_q) << 1;
  // Built from the root including its final digit, so the last RT1 step
  // sees the full magnitude.
  assign hsum     = {1'b0, rt_root[W-1:0]} + {1'b0, a_q};
  assign n2       = (SW'(hsum) << F) >> 1;

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    sa_d   = sa_q;
    sb_d   = sb_q;
    sg_d   = sg_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    num_d  = num_q;
    quo_d  = quo_q;
    zero_d = zero_q;
    in_pop_o = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_pop_o = 1'b1;
          a_d   = re_mag_i;
          b_d   = im_mag_i;
          sa_d  = re_mag_i;
          sb_d  = im_mag_i;
          sg_d  = sign_i;
          rad_d = '0;
          cnt_d = CW'(W - 1);
          st_d  = ST_SQR;
        end
      end
      ST_SQR: begin
        rad_d = sq_sum;
        sa_d  = sa_q << 1;
        sb_d  = sb_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          rem_d  = '0;
          root_d = '0;
          cnt_d  = CW'(RB - 1);
          st_d   = ST_RT1;
        end
      end
      ST_RT1, ST_RT2: begin
        rad_d = rad_q << 2;
        cnt_d = cnt_q - 1'b1;
        if (rt_ge) begin
          rem_d  = rt_rem - rt_trial;
        end else begin
          rem_d  = rt_rem;
        end
        root_d = rt_root;
        if (cnt_q == '0) begin
          if (st_q == ST_RT1) begin
            // rt_root holds the magnitude; set up r = sqrt(half sum)
            root_d = '0;
            rem_d  = '0;
            rad_d  = RW'(n2);
            cnt_d  = CW'(RB - 1);
            a_d    = a_q;
            st_d   = ST_RT2;
          end else if (root_d == '0) begin
            zero_d = 1'b1;
            st_d   = ST_OUT;
          end else begin
            zero_d = 1'b0;
            rem_d  = '0;
            num_d  = NW'(b_q) << F;
            quo_d  = '0;
            cnt_d  = CW'(NW - 1);
            st_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        num_d = num_q << 1;
        cnt_d = cnt_q - 1'b1;
        if (dv_rem >= dv_div) begin
          rem_d = dv_rem - dv_div;
          quo_d = {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_d = dv_rem;
          quo_d = {quo_q[NW-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          st_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hand the result to the output register once it is free.
        if (!out_v_q || out_ready_i) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    a_q    <= a_d;
    b_q    <= b_d;
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    sg_q   <= sg_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
    re_q   <= re_d;
    im_q   <= im_d;
  end

  assign pos_ext = XW'({(W-1){1'b1}});
  assign r_ext   = XW'(root_q);
  assign q_ext   = XW'(quo_q);
  assign r_sat   = (r_ext > pos_ext) ? {(W-1){1'b1}} : root_q[W-2:0];
  assign q_sat   = (q_ext > pos_ext) ? {(W-1){1'b1}} : quo_q[W-2:0];
  assign mag_out = sg_q.re_neg ? q_sat : r_sat;
  assign sgn_out = sg_q.re_neg ? r_sat : q_sat;

  assign re_cmb  = zero_q ? '0 : mag_out;
  assign im_cmb  = zero_q ? '0 :
                   (sg_q.im_neg ? (~{1'b0, sgn_out} + 1'b1) : {1'b0, sgn_out});

  assign load = (st_q == ST_OUT) && (!out_v_q || out_ready_i);

  always_comb begin
    out_v_d = out_v_q;
    re_d    = re_q;
    im_d    = im_q;
    if (load) begin
      out_v_d = 1'b1;
      re_d    = re_cmb;
      im_d    = im_cmb;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  assign out_valid_o = out_v_q;
  assign re_out_o    = re_q;
  assign im_out_o    = im_q;

endmodule

// ----- hdl/complex_square_root_core.sv -----
// Top level of the complex principal square root core.
// Depends on csq_pkg, csq_front, csq_fifo and csq_back.
//
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   s_axis_tvalid/tready_o     tdata: re_in, im_in
//  m_axis    out  m_axis_tvalid_o/tready     tdata: re_out, im_out, zero pad
//
// Sequence: the back end takes one item at a time through W squaring steps,
// two roots of RB = ceil(max(2W, W+1+F)/2) digits each and W+F divide steps
// on the shared bit-serial datapath, and takes no new item until the result
// is handed to the output register. When the root is zero the divide is
// skipped. Input is taken every cycle while the four-entry queue has room.
// Reset clears the queue, the sequencer and the result valid. A stalled
// output holds the result register; the back end finishes the next item and
// waits, and the queue keeps taking items.
module complex_square_root_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // re_in [W-1:0], im_in [2W-1:W], zero pad
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  // re_out [W-2:0], im_out [2W-2:W-1], zero pad
  output logic [((2*DATA_WIDTH-1+7)/8)*8-1:0]    m_axis_tdata_o
);
  import csq_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int ITW   = ((2 * W + 7) / 8) * 8;
  localparam int OTW   = ((2 * W - 1 + 7) / 8) * 8;
  localparam int QW    = 2 * W + 2;
  localparam int DEPTH = 4;

  logic [W-1:0] f_re, f_im, b_re, b_im;
  csq_sign_t    f_sg, b_sg;
  logic [QW-1:0] q_in, q_out;
  logic          q_full, q_valid, q_pop;
  logic [W-2:0]  re_out;
  logic [W-1:0]  im_out;

  // Classify the incoming item: magnitudes and signs.
  csq_front #(.DATA_WIDTH(W), .TDATA_W(ITW)) u_front (
    .tdata_i  (s_axis_tdata_i),
    .re_mag_o (f_re),
    .im_mag_o (f_im),
    .sign_o   (f_sg)
  );

  assign q_in            = {f_sg, f_im, f_re};
  assign s_axis_tready_o = !q_full;

  // Hold classified items until the back end is free.
  csq_fifo #(.WIDTH(QW), .DEPTH(DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid_i),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign b_re = q_out[W-1:0];
  assign b_im = q_out[2*W-1:W];
  assign b_sg = q_out[QW-1:2*W];

  csq_back #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_pop_o    (q_pop),
    .re_mag_i    (b_re),
    .im_mag_i    (b_im),
    .sign_i      (b_sg),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .re_out_o    (re_out),
    .im_out_o    (im_out)
  );

  assign m_axis_tdata_o = OTW'({im_out, re_out});

endmodule
